// ----- rtl/grid_bilinear_climate_query_defines.svh -----
// assertion macros shared by the grid query rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef GRID_BILINEAR_CLIMATE_QUERY_DEFINES_SVH
`define GRID_BILINEAR_CLIMATE_QUERY_DEFINES_SVH
`ifndef ASSERT_OFF
// check with reset qualification
`define GBCQ_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check on a clock only
`define GBCQ_ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GBCQ_ASSERT_RST(label, clk, rst_n, prop, msg)
`define GBCQ_ASSERT_CLK(label, clk, prop, msg)
`endif
`endif

// ----- rtl/gbcq_pkg.sv -----
// shared types, widths and constants of the grid query block
// no dependencies
package gbcq_pkg;

    localparam int DEFAULT_MAX_ROWS = 256;
    localparam int DEFAULT_MAX_COLS = 256;

    localparam int ADDR_W      = 16;
    localparam int STORE_DEPTH = 65536;
    localparam int VAL_W       = 16;
    localparam int COORD_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int T_W         = FRAC_W + 1;
    localparam int WT_W        = 2 * FRAC_W + 1;
    localparam int NBR         = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_CNT_W  = 9;

    localparam int AXIS_STG  = 3;
    localparam int BLEND_STG = 3;
    localparam int NSTG      = AXIS_STG + 2 + BLEND_STG;

    localparam logic [CFG_DATA_W-1:0] INV_CELL_RESET = 32'h0001_0000;
    localparam logic [CFG_CNT_W-1:0]  CNT_RESET      = 9'd2;

    localparam logic signed [VAL_W-1:0] DEFAULT_TEMP   = 16'sd3840;
    localparam logic [VAL_W-1:0]        DEFAULT_PRECIP = 16'd12800;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Y   = 3'd1,
        CFG_INV_CELL   = 3'd2,
        CFG_ROW_COUNT  = 3'd3,
        CFG_COL_COUNT  = 3'd4,
        CFG_TEMP_OFS   = 3'd5,
        CFG_GRID_READY = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        op_t  op;
        logic grid_on;
    } gbcq_ctrl_t;

endpackage

// ----- rtl/grid_bilinear_climate_query.sv -----
// top level of the bilinear grid query block: config registers, pipeline control,
// neighbour addressing and the four store copies
// depends on gbcq_pkg, gbcq_ram, gbcq_axis, gbcq_blend and the defines header
//
// channel  handshake              payload
// in       in_valid / in_stall    op, entry_index, entry_temp, entry_precip, point_x, point_y
// out      out_valid / out_stall  was_query, from_grid, temperature, precipitation
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one word per cycle while out_stall is low; each word goes through the axis, address, store and blend stages
// the four store copies each give one neighbour per cycle, which sets that rate
// reset clears valid bits and sets config registers to their reset values; store contents undefined until written
// a stalled output holds while earlier stages keep filling; in_stall rises once all are full
`include "grid_bilinear_climate_query_defines.svh"

module grid_bilinear_climate_query #(
    parameter int MAX_ROWS = gbcq_pkg::DEFAULT_MAX_ROWS,
    parameter int MAX_COLS = gbcq_pkg::DEFAULT_MAX_COLS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [gbcq_pkg::ADDR_W-1:0]         entry_index,
    input  logic signed [gbcq_pkg::VAL_W-1:0]   entry_temp,
    input  logic [gbcq_pkg::VAL_W-1:0]          entry_precip,
    input  logic signed [gbcq_pkg::COORD_W-1:0] point_x,
    input  logic signed [gbcq_pkg::COORD_W-1:0] point_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                was_query,
    output logic                                from_grid,
    output logic signed [gbcq_pkg::VAL_W-1:0]   temperature,
    output logic [gbcq_pkg::VAL_W-1:0]          precipitation,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gbcq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gbcq_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import gbcq_pkg::*;

    localparam int RCW     = $clog2(MAX_ROWS + 1);
    localparam int CCW     = $clog2(MAX_COLS + 1);
    localparam int RIW     = $clog2(MAX_ROWS);
    localparam int CIW     = $clog2(MAX_COLS);
    localparam int RCMP_W  = (RCW > CFG_CNT_W) ? RCW : CFG_CNT_W;
    localparam int CCMP_W  = (CCW > CFG_CNT_W) ? CCW : CFG_CNT_W;
    localparam int BW      = RIW + CCW;
    localparam int ADR_STG = AXIS_STG;
    localparam int RAM_STG = AXIS_STG + 1;

    localparam logic [T_W-1:0] ONE_Q = {1'b1, {FRAC_W{1'b0}}};

    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    logic [CFG_DATA_W-1:0]     inv_cell_reg;
    logic [CFG_CNT_W-1:0]      row_count_reg;
    logic [CFG_CNT_W-1:0]      col_count_reg;
    logic signed [VAL_W-1:0]   temp_offset_reg;
    logic                      grid_ready_reg;

    logic [RCMP_W-1:0] row_cnt_ext;
    logic [CCMP_W-1:0] col_cnt_ext;
    logic [RCW-1:0]    rows_sat;
    logic [CCW-1:0]    cols_sat;

    logic [NSTG-1:0] en;
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;

    gbcq_ctrl_t         ctrl_reg [ADR_STG+1];
    logic [ADDR_W-1:0]  idx_reg  [ADR_STG+1];
    logic [2*VAL_W-1:0] wd_reg   [ADR_STG+1];
    gbcq_ctrl_t         ctrl_in;

    logic [CIW-1:0] ix;
    logic [RIW-1:0] iy;
    logic [T_W-1:0] tx;
    logic [T_W-1:0] ty;
    logic [T_W-1:0] ux;
    logic [T_W-1:0] uy;

    logic [BW-1:0]     base_prod;
    logic [BW:0]       base_sum;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] row_step;

    logic [NBR-1:0][ADDR_W-1:0]  addr_next;
    logic [NBR-1:0][WT_W-1:0]    w_next;
    logic [NBR-1:0][ADDR_W-1:0]  addr_reg;
    logic [NBR-1:0][WT_W-1:0]    w_reg;
    logic [NBR-1:0][WT_W-1:0]    w5_reg;
    gbcq_ctrl_t                  ctrl5_reg;
    logic [NBR-1:0][2*VAL_W-1:0] rd_data;
    logic                        ram_we;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            inv_cell_reg    <= INV_CELL_RESET;
            row_count_reg   <= CNT_RESET;
            col_count_reg   <= CNT_RESET;
            temp_offset_reg <= '0;
            grid_ready_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ORIGIN_X:   origin_x_reg    <= cfg_data;
                CFG_ORIGIN_Y:   origin_y_reg    <= cfg_data;
                CFG_INV_CELL:   inv_cell_reg    <= cfg_data;
                CFG_ROW_COUNT:  row_count_reg   <= cfg_data[CFG_CNT_W-1:0];
                CFG_COL_COUNT:  col_count_reg   <= cfg_data[CFG_CNT_W-1:0];
                CFG_TEMP_OFS:   temp_offset_reg <= cfg_data[VAL_W-1:0];
                CFG_GRID_READY: grid_ready_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // counts held within two and the grid maximum
    assign row_cnt_ext = RCMP_W'(row_count_reg);
    assign col_cnt_ext = CCMP_W'(col_count_reg);
    assign rows_sat = (row_cnt_ext < RCMP_W'(2))        ? RCW'(2) :
                      (row_cnt_ext > RCMP_W'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(row_cnt_ext);
    assign cols_sat = (col_cnt_ext < CCMP_W'(2))        ? CCW'(2) :
                      (col_cnt_ext > CCMP_W'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(col_cnt_ext);

    // stage enables: a stage loads when empty or when the next one moves
    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || !out_stall;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign v_next = {v_reg[NSTG-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NSTG-1];

    // word control and write payload ride along to the store stage
    assign ctrl_in.op      = op_t'(op);
    assign ctrl_in.grid_on = grid_ready_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ctrl_reg[0] <= ctrl_in;
            idx_reg[0]  <= entry_index;
            wd_reg[0]   <= {entry_temp, entry_precip};
        end
        for (int k = 1; k <= ADR_STG; k++)
        begin
            if (en[k])
            begin
                ctrl_reg[k] <= ctrl_reg[k-1];
                idx_reg[k]  <= idx_reg[k-1];
                wd_reg[k]   <= wd_reg[k-1];
            end
        end
    end

    gbcq_axis #(
        .MAX_CNT (MAX_COLS)
    ) u_axis_x (
        .clk      (clk),
        .en       (en[AXIS_STG-1:0]),
        .p        (point_x),
        .origin   (origin_x_reg),
        .inv_cell (inv_cell_reg),
        .cnt      (cols_sat),
        .ix       (ix),
        .t        (tx)
    );

    gbcq_axis #(
        .MAX_CNT (MAX_ROWS)
    ) u_axis_y (
        .clk      (clk),
        .en       (en[AXIS_STG-1:0]),
        .p        (point_y),
        .origin   (origin_y_reg),
        .inv_cell (inv_cell_reg),
        .cnt      (rows_sat),
        .ix       (iy),
        .t        (ty)
    );

    // stage 4: neighbour addresses and weights
    assign base_prod = BW'(iy) * BW'(cols_sat);
    assign base_sum  = {1'b0, base_prod} + (BW + 1)'(ix);
    assign base      = ADDR_W'(base_sum);
    assign row_step  = ADDR_W'(cols_sat);

    assign addr_next[0] = base;
    assign addr_next[1] = base + ADDR_W'(1);
    assign addr_next[2] = base + row_step;
    assign addr_next[3] = base + row_step + ADDR_W'(1);

    assign ux = ONE_Q - tx;
    assign uy = ONE_Q - ty;

    assign w_next[0] = WT_W'((2 * T_W)'(ux) * (2 * T_W)'(uy));
    assign w_next[1] = WT_W'((2 * T_W)'(tx) * (2 * T_W)'(uy));
    assign w_next[2] = WT_W'((2 * T_W)'(ux) * (2 * T_W)'(ty));
    assign w_next[3] = WT_W'((2 * T_W)'(tx) * (2 * T_W)'(ty));

    always_ff @(posedge clk)
    begin
        if (en[ADR_STG])
        begin
            addr_reg <= addr_next;
            w_reg    <= w_next;
        end
        if (en[RAM_STG])
        begin
            w5_reg    <= w_reg;
            ctrl5_reg <= ctrl_reg[ADR_STG];
        end
    end

    // stage 5: every copy takes each write, each copy reads one neighbour
    assign ram_we = en[RAM_STG] && v_reg[ADR_STG] && (ctrl_reg[ADR_STG].op == OP_WRITE);

    for (genvar g = 0; g < NBR; g++)
    begin : g_store
        gbcq_ram #(
            .WIDTH (2 * VAL_W),
            .DEPTH (STORE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we),
            .waddr (idx_reg[ADR_STG]),
            .wdata (wd_reg[ADR_STG]),
            .re    (en[RAM_STG]),
            .raddr (addr_reg[g]),
            .rdata (rd_data[g])
        );
    end

    gbcq_blend u_blend (
        .clk           (clk),
        .en            (en[NSTG-1:NSTG-BLEND_STG]),
        .weight        (w5_reg),
        .nbr_val       (rd_data),
        .ctrl_in       (ctrl5_reg),
        .offset        (temp_offset_reg),
        .was_query     (was_query),
        .from_grid     (from_grid),
        .temperature   (temperature),
        .precipitation (precipitation)
    );

    `GBCQ_ASSERT_RST(a_accept_lands, clk, rst_n, in_valid && !in_stall |=> v_reg[0], "word lost")
    `GBCQ_ASSERT_RST(a_stall_full, clk, rst_n, in_stall |-> (&v_reg) && out_stall, "early stall")
    `GBCQ_ASSERT_RST(a_no_repeat, clk, rst_n, out_valid && !out_stall && !v_reg[NSTG-2] |=> !out_valid, "repeat")

endmodule

// ----- rtl/gbcq_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// depends on gbcq_pkg for default sizes only
module gbcq_ram #(
    parameter int WIDTH = 2 * gbcq_pkg::VAL_W,
    parameter int DEPTH = gbcq_pkg::STORE_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/gbcq_axis.sv -----
// three-stage map of one query coordinate to cell index and fraction
// depends on gbcq_pkg and grid_bilinear_climate_query_defines.svh
`include "grid_bilinear_climate_query_defines.svh"

module gbcq_axis #(
    parameter int MAX_CNT = gbcq_pkg::DEFAULT_MAX_COLS,
    localparam int CW = $clog2(MAX_CNT + 1),
    localparam int IW = $clog2(MAX_CNT)
) (
    input  logic                                clk,
    input  logic [gbcq_pkg::AXIS_STG-1:0]       en,
    input  logic signed [gbcq_pkg::COORD_W-1:0] p,
    input  logic signed [gbcq_pkg::COORD_W-1:0] origin,
    input  logic [gbcq_pkg::COORD_W-1:0]        inv_cell,
    input  logic [CW-1:0]                       cnt,
    output logic [IW-1:0]                       ix,
    output logic [gbcq_pkg::T_W-1:0]            t
);
    import gbcq_pkg::*;

    localparam int PROD_W = 2 * COORD_W;
    localparam int FW     = PROD_W - FRAC_W;
    localparam int LW     = CW + FRAC_W;

    logic signed [COORD_W:0] diff;
    logic [COORD_W-1:0]      mag_next;
    logic [COORD_W-1:0]      mag_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [FW-1:0]           f;
    logic [CW-1:0]           top_cell;
    logic [LW-1:0]           lim;
    logic [LW-1:0]           fc;
    logic [CW-1:0]           whole;
    logic                    at_edge;
    logic [IW-1:0]           ix_next;
    logic [T_W-1:0]          t_next;
    logic [IW-1:0]           ix_reg;
    logic [T_W-1:0]          t_reg;

    // stage 1: offset from origin, negative or zero maps to zero
    assign diff     = {p[COORD_W-1], p} - {origin[COORD_W-1], origin};
    assign mag_next = (!diff[COORD_W] && (diff != '0)) ? diff[COORD_W-1:0] : '0;

    // stage 3: clamp to the last grid line, keep index at most count minus two
    assign f        = prod_reg[PROD_W-1:FRAC_W];
    assign top_cell = cnt - CW'(1);
    assign lim      = {top_cell, {FRAC_W{1'b0}}};
    assign fc       = (f > FW'(lim)) ? lim : LW'(f);
    assign whole    = fc[LW-1:FRAC_W];
    assign at_edge  = (whole == top_cell);
    assign ix_next  = at_edge ? IW'(cnt - CW'(2)) : IW'(whole);
    assign t_next   = at_edge ? {1'b1, {FRAC_W{1'b0}}} : {1'b0, fc[FRAC_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mag_reg <= mag_next;
        end
        if (en[1])
        begin
            prod_reg <= mag_reg * inv_cell;
        end
        if (en[2])
        begin
            ix_reg <= ix_next;
            t_reg  <= t_next;
        end
    end

    assign ix = ix_reg;
    assign t  = t_reg;

    `GBCQ_ASSERT_CLK(a_frac_max, clk, t_reg[FRAC_W] |-> (t_reg[FRAC_W-1:0] == '0), "frac > 1")

endmodule

// ----- rtl/gbcq_blend.sv -----
// three-stage weighted sum of four neighbours, rounding, offset and saturation, or defaults when the grid is off
// depends on gbcq_pkg
module gbcq_blend (
    input  logic                                              clk,
    input  logic [gbcq_pkg::BLEND_STG-1:0]                    en,
    input  logic [gbcq_pkg::NBR-1:0][gbcq_pkg::WT_W-1:0]      weight,
    input  logic [gbcq_pkg::NBR-1:0][2*gbcq_pkg::VAL_W-1:0]   nbr_val,
    input  gbcq_pkg::gbcq_ctrl_t                              ctrl_in,
    input  logic signed [gbcq_pkg::VAL_W-1:0]                 offset,
    output logic                                              was_query,
    output logic                                              from_grid,
    output logic signed [gbcq_pkg::VAL_W-1:0]                 temperature,
    output logic [gbcq_pkg::VAL_W-1:0]                        precipitation
);
    import gbcq_pkg::*;

    localparam int PT_W   = WT_W + 1 + VAL_W;
    localparam int PP_W   = WT_W + VAL_W;
    localparam int RND_SH = 2 * FRAC_W;
    localparam int TI_W   = PT_W - RND_SH;
    localparam int TS_W   = TI_W + 1;

    localparam logic signed [PT_W-1:0] HALF_T =
        {{(PT_W - RND_SH){1'b0}}, 1'b1, {(RND_SH - 1){1'b0}}};
    localparam logic [PP_W-1:0] HALF_P =
        {{(PP_W - RND_SH){1'b0}}, 1'b1, {(RND_SH - 1){1'b0}}};
    localparam logic signed [TS_W-1:0] T_HI = TS_W'(2 ** (VAL_W - 1) - 1);
    localparam logic signed [TS_W-1:0] T_LO = TS_W'(-(2 ** (VAL_W - 1)));

    logic signed [PT_W-1:0] pt_reg [NBR];
    logic [PP_W-1:0]        pp_reg [NBR];
    gbcq_ctrl_t             ctrl_reg [2];
    logic signed [PT_W-1:0] st_reg;
    logic [PP_W-1:0]        sp_reg;

    logic signed [PT_W-1:0] st_rnd;
    logic [PP_W-1:0]        sp_rnd;
    logic signed [TI_W-1:0] t_int;
    logic signed [TS_W-1:0] t_sum;
    logic signed [VAL_W-1:0] t_sat;

    logic                    was_query_next;
    logic                    from_grid_next;
    logic signed [VAL_W-1:0] temp_next;
    logic [VAL_W-1:0]        precip_next;
    logic                    was_query_reg;
    logic                    from_grid_reg;
    logic signed [VAL_W-1:0] temp_reg;
    logic [VAL_W-1:0]        precip_reg;

    // stage 6 products, stage 7 sums
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < NBR; k++)
            begin
                pt_reg[k] <= $signed({1'b0, weight[k]}) * $signed(nbr_val[k][2*VAL_W-1:VAL_W]);
                pp_reg[k] <= weight[k] * nbr_val[k][VAL_W-1:0];
            end
            ctrl_reg[0] <= ctrl_in;
        end
        if (en[1])
        begin
            st_reg      <= pt_reg[0] + pt_reg[1] + pt_reg[2] + pt_reg[3];
            sp_reg      <= pp_reg[0] + pp_reg[1] + pp_reg[2] + pp_reg[3];
            ctrl_reg[1] <= ctrl_reg[0];
        end
    end

    // stage 8: round half up, add offset, saturate
    assign st_rnd = st_reg + HALF_T;
    assign sp_rnd = sp_reg + HALF_P;
    assign t_int  = st_rnd[PT_W-1:RND_SH];
    assign t_sum  = TS_W'(t_int) + TS_W'(offset);
    assign t_sat  = (t_sum > T_HI) ? VAL_W'(T_HI) :
                    (t_sum < T_LO) ? VAL_W'(T_LO) : VAL_W'(t_sum);

    always_comb
    begin
        was_query_next = 1'b0;
        from_grid_next = 1'b0;
        temp_next      = '0;
        precip_next    = '0;
        if (ctrl_reg[1].op == OP_QUERY)
        begin
            was_query_next = 1'b1;
            if (ctrl_reg[1].grid_on)
            begin
                from_grid_next = 1'b1;
                temp_next      = t_sat;
                precip_next    = sp_rnd[RND_SH+VAL_W-1:RND_SH];
            end
            else
            begin
                temp_next   = DEFAULT_TEMP;
                precip_next = DEFAULT_PRECIP;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            was_query_reg <= was_query_next;
            from_grid_reg <= from_grid_next;
            temp_reg      <= temp_next;
            precip_reg    <= precip_next;
        end
    end

    assign was_query     = was_query_reg;
    assign from_grid     = from_grid_reg;
    assign temperature   = temp_reg;
    assign precipitation = precip_reg;

endmodule

// ----- sim/climate_query_monitor.sv -----
`timescale 1ns / 1ps
// scoreboard for the grid query block: mirrors the config registers and both field stores,
// predicts the result of each word accepted at the input and compares it at the output
// depends on gbcq_pkg
module climate_query_monitor #(
    parameter int MAX_ROWS = gbcq_pkg::DEFAULT_MAX_ROWS,
    parameter int MAX_COLS = gbcq_pkg::DEFAULT_MAX_COLS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                op,
    input  logic [gbcq_pkg::ADDR_W-1:0]         entry_index,
    input  logic signed [gbcq_pkg::VAL_W-1:0]   entry_temp,
    input  logic [gbcq_pkg::VAL_W-1:0]          entry_precip,
    input  logic signed [gbcq_pkg::COORD_W-1:0] point_x,
    input  logic signed [gbcq_pkg::COORD_W-1:0] point_y,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                was_query,
    input  logic                                from_grid,
    input  logic signed [gbcq_pkg::VAL_W-1:0]   temperature,
    input  logic [gbcq_pkg::VAL_W-1:0]          precipitation,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [gbcq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gbcq_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  fail_count,
    output int                                  awaiting
);
    import gbcq_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic              was_query;
        logic              from_grid;
        logic signed [15:0] temperature;
        logic [15:0]       precipitation;
    } reading_t;

    localparam longint HALF_Q32 = longint'(1) <<< 31;

    logic signed [15:0] temp_mem [0:STORE_DEPTH-1];
    logic [15:0]        precip_mem [0:STORE_DEPTH-1];

    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic [31:0]        inv_cell;
    logic [8:0]         rows_cfg;
    logic [8:0]         cols_cfg;
    logic signed [15:0] temp_ofs;
    logic               ready_cfg;

    reading_t readings_due [$];
    int       bad_words = 0;
    int       words_due = 0;

    assign fail_count = bad_words;
    assign awaiting   = words_due;

    function automatic int unsigned clip_count(input logic [8:0] n, input int unsigned top);
        if (n < 2)
            return 2;
        if (n > top)
            return top;
        return n;
    endfunction

    // clamped cell coordinate along one axis, Q16.16
    function automatic longint cell_pos(input logic signed [31:0] p, input logic signed [31:0] o,
                                        input int unsigned cnt);
        longint diff;
        longint lim;
        u64_t   scaled;
        diff = longint'(p) - longint'(o);
        lim  = longint'(cnt - 1) <<< 16;
        if (diff <= 0)
            return 0;
        scaled = (u64_t'(diff) * u64_t'(inv_cell)) >> 16;
        if (scaled > u64_t'(lim))
            return lim;
        return longint'(scaled);
    endfunction

    function automatic reading_t interpolate_point(input logic signed [31:0] px,
                                                   input logic signed [31:0] py);
        reading_t     r;
        int unsigned  rows, cols, ix, iy;
        longint       fx, fy, tx, ty, w00, w10, w01, w11, acc_t, acc_p;
        logic [15:0]  a00, a10, a01, a11;
        r.was_query = 1'b1;
        if (!ready_cfg) begin
            r.from_grid     = 1'b0;
            r.temperature   = DEFAULT_TEMP;
            r.precipitation = DEFAULT_PRECIP;
            return r;
        end
        rows = clip_count(rows_cfg, MAX_ROWS);
        cols = clip_count(cols_cfg, MAX_COLS);
        fx = cell_pos(px, org_x, cols);
        fy = cell_pos(py, org_y, rows);
        ix = 32'(fx >>> 16);
        iy = 32'(fy >>> 16);
        if (ix > cols - 2)
            ix = cols - 2;
        if (iy > rows - 2)
            iy = rows - 2;
        tx = fx - (longint'(ix) <<< 16);
        ty = fy - (longint'(iy) <<< 16);
        w00 = (65536 - tx) * (65536 - ty);
        w10 = tx * (65536 - ty);
        w01 = (65536 - tx) * ty;
        w11 = tx * ty;
        a00 = 16'(iy * cols + ix);
        a10 = 16'(iy * cols + ix + 1);
        a01 = 16'((iy + 1) * cols + ix);
        a11 = 16'((iy + 1) * cols + ix + 1);
        acc_t = w00 * longint'(temp_mem[a00]) + w10 * longint'(temp_mem[a10])
              + w01 * longint'(temp_mem[a01]) + w11 * longint'(temp_mem[a11]);
        acc_p = w00 * longint'(precip_mem[a00]) + w10 * longint'(precip_mem[a10])
              + w01 * longint'(precip_mem[a01]) + w11 * longint'(precip_mem[a11]);
        // round half up, then offset and saturate
        acc_t = ((acc_t + HALF_Q32) >>> 32) + longint'(temp_ofs);
        if (acc_t > 32767)
            acc_t = 32767;
        if (acc_t < -32768)
            acc_t = -32768;
        acc_p = (acc_p + HALF_Q32) >>> 32;
        if (acc_p > 65535)
            acc_p = 65535;
        r.from_grid     = 1'b1;
        r.temperature   = acc_t[15:0];
        r.precipitation = acc_p[15:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        reading_t seen;
        if (!rst_n)
        begin
            org_x     = '0;
            org_y     = '0;
            inv_cell  = INV_CELL_RESET;
            rows_cfg  = CNT_RESET;
            cols_cfg  = CNT_RESET;
            temp_ofs  = '0;
            ready_cfg = 1'b0;
            readings_due.delete();
            words_due = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_ORIGIN_X:   org_x = cfg_data;
                    CFG_ORIGIN_Y:   org_y = cfg_data;
                    CFG_INV_CELL:   inv_cell = cfg_data;
                    CFG_ROW_COUNT:  rows_cfg = cfg_data[8:0];
                    CFG_COL_COUNT:  cols_cfg = cfg_data[8:0];
                    CFG_TEMP_OFS:   temp_ofs = cfg_data[15:0];
                    CFG_GRID_READY: ready_cfg = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (op_t'(op) == OP_WRITE)
                begin
                    temp_mem[entry_index]   = entry_temp;
                    precip_mem[entry_index] = entry_precip;
                    want = '0;
                end
                else
                    want = interpolate_point(point_x, point_y);
                readings_due.insert(readings_due.size(), want);
            end
            if (out_valid && !out_stall)
            begin
                seen.was_query     = was_query;
                seen.from_grid     = from_grid;
                seen.temperature   = temperature;
                seen.precipitation = precipitation;
                if (readings_due.size() == 0)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("unexpected word: q=%0b g=%0b t=%0d p=%0d", seen.was_query,
                                 seen.from_grid, $signed(seen.temperature), seen.precipitation);
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (seen.was_query !== want.was_query || seen.from_grid !== want.from_grid
                        || seen.temperature !== want.temperature
                        || seen.precipitation !== want.precipitation)
                    begin
                        bad_words++;
                        if (bad_words <= 10)
                            $display("mismatch: expected q=%0b g=%0b t=%0d p=%0d",
                                     want.was_query, want.from_grid, $signed(want.temperature),
                                     want.precipitation,
                                     ", got q=%0b g=%0b t=%0d p=%0d",
                                     seen.was_query, seen.from_grid,
                                     $signed(seen.temperature), seen.precipitation);
                    end
                end
            end
            words_due = readings_due.size();
        end
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// top of the grid query testbench: clock, reset, query/write stimulus, register writes
// and output stalls; checking is done by climate_query_monitor
// depends on gbcq_pkg, grid_bilinear_climate_query and climate_query_monitor
module tb;
    import gbcq_pkg::*;

    localparam int     PHASES          = 9;
    localparam int     WORDS_PER_PHASE = 70;
    localparam int     MAX_ROWS        = DEFAULT_MAX_ROWS;
    localparam int     MAX_COLS        = DEFAULT_MAX_COLS;
    localparam longint COORD_MAX       = 64'sd2147483647;
    localparam longint COORD_MIN       = -64'sd2147483648;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        op           = OP_QUERY;
    logic [15:0] entry_index  = '0;
    logic [15:0] entry_temp   = '0;
    logic [15:0] entry_precip = '0;
    logic [31:0] point_x      = '0;
    logic [31:0] point_y      = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic        was_query;
    logic        from_grid;
    logic [15:0] temperature;
    logic [15:0] precipitation;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index    = CFG_ORIGIN_X;
    logic [31:0] cfg_data     = '0;

    int fail_count;
    int awaiting;
    int steady_left = 0;

    logic signed [31:0] cur_ox  = '0;
    logic signed [31:0] cur_oy  = '0;
    logic [31:0]        cur_inv = INV_CELL_RESET;

    int row_set [0:PHASES-1] = '{2, 3, 8, 511, 2, 0, 12, 6, 5};
    int col_set [0:PHASES-1] = '{2, 5, 8, 2, 256, 17, 1, 6, 8};

    grid_bilinear_climate_query dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .entry_index   (entry_index),
        .entry_temp    (entry_temp),
        .entry_precip  (entry_precip),
        .point_x       (point_x),
        .point_y       (point_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .was_query     (was_query),
        .from_grid     (from_grid),
        .temperature   (temperature),
        .precipitation (precipitation),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    climate_query_monitor checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .entry_index   (entry_index),
        .entry_temp    (entry_temp),
        .entry_precip  (entry_precip),
        .point_x       (point_x),
        .point_y       (point_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .was_query     (was_query),
        .from_grid     (from_grid),
        .temperature   (temperature),
        .precipitation (precipitation),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .awaiting      (awaiting)
    );

    always #4 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : out_stall_gen
        int unsigned roll, open_len, hold_len;
        forever
        begin
            roll     = $urandom_range(0, 99);
            open_len = (roll < 10) ? $urandom_range(100, 300) : $urandom_range(1, 12);
            roll     = $urandom_range(0, 99);
            hold_len = (roll < 80) ? $urandom_range(1, 3)
                     : (roll < 96) ? $urandom_range(4, 12) : $urandom_range(25, 60);
            repeat (open_len) @(negedge clk) out_stall <= 1'b0;
            repeat (hold_len) @(negedge clk) out_stall <= 1'b1;
        end
    end

    function automatic logic [15:0] pick_temp();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 16'h8000;
        if (roll == 1)
            return 16'h7FFF;
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_precip();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 16'h0000;
        if (roll == 1)
            return 16'hFFFF;
        return $urandom;
    endfunction

    // coordinate that mostly lands on or just around the grid along one axis
    function automatic logic [31:0] aim(input logic signed [31:0] org, input logic [31:0] inv,
                                        input int unsigned cnt);
        int unsigned roll;
        longint      f, d, p;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return $urandom;
        if (roll < 25)
        begin
            case ($urandom_range(0, 4))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return org;
                3:       return org + 1;
                default: return org - 1;
            endcase
        end
        f = longint'($urandom_range(0, (cnt + 2) * 65536)) - 65536;
        d = (inv == 0) ? f : (f * 65536) / longint'(inv);
        p = longint'(org) + d;
        if (p > COORD_MAX)
            p = COORD_MAX;
        if (p < COORD_MIN)
            p = COORD_MIN;
        return p[31:0];
    endfunction

    task automatic put_word(input op_t kind, input logic [15:0] idx, input logic [15:0] t,
                            input logic [15:0] pr, input logic [31:0] x, input logic [31:0] y);
        int unsigned roll, gap;
        @(negedge clk);
        in_valid     <= 1'b1;
        op           <= kind;
        entry_index  <= idx;
        entry_temp   <= t;
        entry_precip <= pr;
        point_x      <= x;
        point_y      <= y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        roll = $urandom_range(0, 99);
        if (steady_left > 0)
        begin
            steady_left--;
            gap = 0;
        end
        else if (roll < 55)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else if (roll < 98)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 50);
        if (gap != 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic write_entry(input logic [15:0] idx, input logic [15:0] t,
                               input logic [15:0] pr);
        put_word(OP_WRITE, idx, t, pr, $urandom, $urandom);
    endtask

    task automatic send_query(input logic [31:0] x, input logic [31:0] y);
        put_word(OP_QUERY, $urandom, $urandom, $urandom, x, y);
    endtask

    // hold the sender until every word has come back, then let the pipeline empty
    task automatic settle();
        @(negedge clk) in_valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic set_reg(input cfg_reg_t r, input logic [31:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    initial
    begin : main
        int unsigned        ph, k, n, rows_used, cols_used, roll;
        logic [31:0]        junk;
        logic [15:0]        ofs;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // grid not ready: defaults
        send_query(32'h8000_0000, 32'h7FFF_FFFF);
        send_query(32'h7FFF_FFFF, 32'h8000_0000);
        write_entry(16'd0, 16'h8000, 16'h0000);
        write_entry(16'd1, 16'h7FFF, 16'hFFFF);
        write_entry(16'd2, 16'h5555, 16'hAAAA);
        write_entry(16'd3, 16'hAAAA, 16'h5555);
        write_entry(16'hFFFF, 16'h7FFF, 16'hFFFF);
        settle();
        set_reg(CFG_GRID_READY, 32'd1);
        // corners, center, a rounding tie, below and beyond the grid
        send_query(32'h0000_0000, 32'h0000_0000);
        send_query(32'h0001_0000, 32'h0000_0000);
        send_query(32'h0000_0000, 32'h0001_0000);
        send_query(32'h0001_0000, 32'h0001_0000);
        send_query(32'h0000_8000, 32'h0000_8000);
        send_query(32'h0000_8000, 32'h0000_0000);
        send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        // offset saturation both ways
        settle();
        set_reg(CFG_TEMP_OFS, 32'h0000_7FFF);
        send_query(32'h0001_0000, 32'h0000_0000);
        settle();
        set_reg(CFG_TEMP_OFS, 32'hFFFF_8000);
        send_query(32'h0000_0000, 32'h0000_0000);
        // zero reciprocal cell size
        settle();
        set_reg(CFG_INV_CELL, 32'd0);
        send_query(32'h0001_8000, 32'h0000_C000);
        // counts below range
        settle();
        set_reg(CFG_ROW_COUNT, 32'd0);
        set_reg(CFG_COL_COUNT, 32'd1);
        set_reg(CFG_INV_CELL, INV_CELL_RESET);
        send_query(32'h0001_8000, 32'h0001_8000);

        for (ph = 0; ph < PHASES; ph++)
        begin
            rows_used = (row_set[ph] < 2) ? 2 : (row_set[ph] > MAX_ROWS) ? MAX_ROWS : row_set[ph];
            cols_used = (col_set[ph] < 2) ? 2 : (col_set[ph] > MAX_COLS) ? MAX_COLS : col_set[ph];
            n = rows_used * cols_used;
            junk = $urandom;
            cur_ox = ($urandom_range(0, 3) == 0) ? 32'd0
                   : int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            cur_oy = ($urandom_range(0, 3) == 0) ? 32'd0
                   : int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            if (ph == 3)
            begin
                cur_ox = 32'h8000_0000;
                cur_oy = 32'h7FFF_FFFF;
            end
            if (ph == 4)
            begin
                cur_ox = 32'h7FFF_FFFF;
                cur_oy = 32'h8000_0000;
            end
            case (ph)
                0: cur_inv = INV_CELL_RESET;
                5: cur_inv = 32'd0;
                7: cur_inv = 32'hFFFF_FFFF;
                8: cur_inv = 32'd1;
                default:
                    case ($urandom_range(0, 3))
                        0:       cur_inv = 32'h0001_0000;
                        1:       cur_inv = 32'h0000_8000;
                        2:       cur_inv = 32'h0002_0000;
                        default: cur_inv = $urandom_range(32'h0000_1000, 32'h0010_0000);
                    endcase
            endcase
            ofs = $urandom;
            if (ph == 1)
                ofs = 16'h7FFF;
            if (ph == 2)
                ofs = 16'h8000;

            settle();
            set_reg(CFG_ORIGIN_X, cur_ox);
            set_reg(CFG_ORIGIN_Y, cur_oy);
            set_reg(CFG_INV_CELL, cur_inv);
            set_reg(CFG_ROW_COUNT, {junk[31:9], 9'(row_set[ph])});
            set_reg(CFG_COL_COUNT, {junk[31:9], 9'(col_set[ph])});
            set_reg(CFG_TEMP_OFS, {junk[31:16], ofs});
            set_reg(CFG_GRID_READY, {junk[31:1], (ph != 6)});

            steady_left = 40;
            for (k = 0; k < n; k++)
                write_entry(k, pick_temp(), pick_precip());
            for (k = 0; k < WORDS_PER_PHASE; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 82)
                    send_query(aim(cur_ox, cur_inv, cols_used), aim(cur_oy, cur_inv, rows_used));
                else if (roll < 94)
                    write_entry($urandom_range(0, n - 1), pick_temp(), pick_precip());
                else
                    write_entry($urandom, pick_temp(), pick_precip());
                if ($urandom_range(0, 99) == 0)
                    settle();
            end
        end

        settle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- grid_bilinear_climate_query.f -----
+incdir+rtl
rtl/gbcq_pkg.sv
rtl/gbcq_ram.sv
rtl/gbcq_axis.sv
rtl/gbcq_blend.sv
rtl/grid_bilinear_climate_query.sv
sim/climate_query_monitor.sv
sim/tb.sv
